[hdl/aal_pkg.sv]
// ----------------------------------------------------------------------------
// aal_pkg - shared types and constants of the adaptation loop chain
// Fixed-point constants, rest thresholds, output scales and the divider
// request bundle.
// ----------------------------------------------------------------------------
package aal_pkg;

    // rest thresholds 1e-5^(1/2^(j+1)), unsigned Q6.26
    localparam logic [31:0] REST_THR [8] = '{
        32'd212217,   32'd3773809,  32'd15914020, 32'd32679837,
        32'd46830618, 32'd56060231, 32'd61336274, 32'd64157677
    };

    // 100 / (1 - last rest threshold), Q16.16, by number of stages
    localparam logic [31:0] DB_SCALE [8] = '{
        32'd6574389,  32'd6944103,  32'd8590800,   32'd12774244,
        32'd21688495, 32'd39806239, 32'd76188418,  32'd149026374
    };

    localparam logic [31:0] MIN_IN_Q26 = 32'd671;
    localparam logic [31:0] ONE_Q26    = 32'h0400_0000;
    localparam logic [32:0] ONE_Q32    = 33'h1_0000_0000;
    localparam logic [31:0] EXPFAC_Q32 = 32'd954447776;
    localparam logic [30:0] FACTOR_Q26 = 31'd1207946130;
    localparam logic [31:0] OFFSET_Q26 = 32'd536864201;
    localparam logic [31:0] RECIP3     = 32'hAAAA_AAAB;
    localparam logic [31:0] RECIP5     = 32'hCCCC_CCCD;

    // register map, word index
    typedef enum logic [2:0] {
        REG_STAGE0_DECAY = 3'd0,
        REG_STAGE1_DECAY = 3'd1,
        REG_STAGE2_DECAY = 3'd2,
        REG_STAGE3_DECAY = 3'd3,
        REG_STAGE4_DECAY = 3'd4,
        REG_OUTPUT_DECAY = 3'd5,
        REG_FLOOR_EN     = 3'd6,
        REG_LOWPASS_EN   = 3'd7
    } reg_idx_t;

    // divider request: numerator is {rem_init, low}, rem_init below den
    typedef struct packed {
        logic        start;
        logic [33:0] rem_init;
        logic [31:0] low;
        logic [33:0] den;
    } div_req_t;

endpackage

[hdl/aal_cell.sv]
// ----------------------------------------------------------------------------
// aal_cell - one divisor cell of the loop chain
// Holds one stage divisor and hands it to its neighbour on each shift.
// ----------------------------------------------------------------------------
module aal_cell #(
    parameter logic [31:0] RESET_VALUE = 32'd0
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        shift,
    input  logic [31:0] d_in,
    output logic [31:0] d_out
);
    logic [31:0] divisor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divisor_reg <= RESET_VALUE;
        end
        else if (shift)
        begin
            divisor_reg <= d_in;
        end
    end

    assign d_out = divisor_reg;
endmodule

[hdl/aal_div.sv]
// ----------------------------------------------------------------------------
// aal_div - restoring divider, one quotient bit per cycle
// 32 quotient bits of {rem_init, low} / den; done pulses when ready.
// ----------------------------------------------------------------------------
module aal_div (
    input  logic              clk,
    input  logic              rst_n,
    input  aal_pkg::div_req_t req,
    output logic              done,
    output logic [31:0]       quot
);
    import aal_pkg::*;

    logic [33:0] rem_reg;
    logic [31:0] low_reg;
    logic [33:0] den_reg;
    logic [31:0] quot_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [34:0] trial;
    logic [34:0] diff;
    logic        ge;

    assign trial = {rem_reg, low_reg[31]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= req.rem_init;
            low_reg  <= req.low;
            den_reg  <= req.den;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? diff[33:0] : trial[33:0];
            low_reg  <= {low_reg[30:0], 1'b0};
            quot_reg <= {quot_reg[30:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;
endmodule

[hdl/auditory_adaptation_loops_core.sv]
// ----------------------------------------------------------------------------
// auditory_adaptation_loops_core - five-stage adaptive divisive loop chain
// One audio amplitude in, one model-unit value out per beat.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake            | payload
//  ----------+-----------+----------------------+--------------------------
//  input     | in        | in_valid / in_ready  | sample, Q4.20 unsigned
//  output    | out       | out_valid / out_ready| model_units, Q13.11 signed
//  config    | in        | APB psel/penable     | paddr, pwdata, prdata
//
//  Flow: one sample at a time. Each stage forms the quotient of its input and
//  divisor, runs the exp and sigmoid sequence only when the quotient exceeds
//  1, and updates the divisor; the divider serves both the quotient and the
//  sigmoid, and all products go through the single shared multiplier. Rescale
//  and lowpass follow the last stage (rescale only, with the lowpass off).
//  Reset: divisors return to their rest thresholds, filter state to zero,
//  registers to their defaults. No clearing pass.
//  Stalls: a finished result waits in the output register; a new sample is
//  taken only once the sequencer has returned to idle.
// ----------------------------------------------------------------------------
module auditory_adaptation_loops_core #(
    parameter int STAGE_COUNT = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // sample beats
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [23:0] sample,
    // result beats
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [24:0] model_units
);
    import aal_pkg::*;

    localparam int IDX_W = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STAGE_COUNT - 1);
    localparam logic [2:0] LAST = 3'(STAGE_COUNT - 1);
    localparam logic signed [67:0] OUT_MAX = 68'sd16777215;
    localparam logic signed [67:0] OUT_MIN = -68'sd16777216;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CHK, ST_DIVW, ST_QCHK, ST_AMUL, ST_A,
        ST_H1, ST_H2, ST_H3, ST_H4, ST_S1, ST_S2, ST_SIG, ST_SIGW,
        ST_U1, ST_U2, ST_U3, ST_R1, ST_R2, ST_L1, ST_L2, ST_L3, ST_FIN
    } state_t;

    // configuration registers
    logic [31:0] stage0_decay_reg, stage1_decay_reg, stage2_decay_reg;
    logic [31:0] stage3_decay_reg, stage4_decay_reg, output_decay_reg;
    logic        floor_en_reg, lowpass_en_reg;

    // datapath
    state_t              state_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [31:0]         x_reg;
    logic [31:0]         q_reg;
    logic [29:0]         a_reg;
    logic [29:0]         t_reg;
    logic [32:0]         p_reg;
    logic [2:0]          k_reg;
    logic [2:0]          sq_reg;
    logic signed [67:0]  acc_reg;
    logic signed [67:0]  mul_reg;
    logic signed [24:0]  val_reg;
    logic signed [24:0]  ofv_reg;
    logic signed [24:0]  out_reg;
    logic                out_valid_reg;

    logic signed [33:0]  mul_a, mul_b;
    logic [31:0]         cell_out [STAGE_COUNT];
    logic [31:0]         head_d;
    logic [31:0]         dec_cur;
    logic [31:0]         rest_cur;
    logic [2:0]          idx_ext;
    logic                cell_shift;
    logic [31:0]         upd_nd;
    logic [67:0]         upd_sum;
    logic                q_sat;
    div_req_t            div_req;
    logic                div_done;
    logic [31:0]         div_quot;
    logic [29:0]         t_sel;
    logic [29:0]         h_quo;
    logic signed [67:0]  prod_abs;
    logic signed [67:0]  prod_rnd;
    logic signed [67:0]  prod_val;
    logic signed [67:0]  lp_sum;
    logic signed [67:0]  lp_val;
    logic [31:0]         in_x;
    logic                cfg_wr;

    function automatic logic signed [24:0] sat25(input logic signed [67:0] v);
        if (v > OUT_MAX)
        begin
            return 25'sh0FF_FFFF;
        end
        else if (v < OUT_MIN)
        begin
            return -25'sh100_0000;
        end
        return v[24:0];
    endfunction

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage0_decay_reg <= 32'd4241614366;
            stage1_decay_reg <= 32'd4289601936;
            stage2_decay_reg <= 32'd4292886904;
            stage3_decay_reg <= 32'd4293906413;
            stage4_decay_reg <= 32'd4294430459;
            output_decay_reg <= 32'd4281566479;
            floor_en_reg     <= 1'b1;
            lowpass_en_reg   <= 1'b1;
        end
        else if (cfg_wr)
        begin
            case (reg_idx_t'(paddr[4:2]))
                REG_STAGE0_DECAY: stage0_decay_reg <= pwdata;
                REG_STAGE1_DECAY: stage1_decay_reg <= pwdata;
                REG_STAGE2_DECAY: stage2_decay_reg <= pwdata;
                REG_STAGE3_DECAY: stage3_decay_reg <= pwdata;
                REG_STAGE4_DECAY: stage4_decay_reg <= pwdata;
                REG_OUTPUT_DECAY: output_decay_reg <= pwdata;
                REG_FLOOR_EN:     floor_en_reg     <= pwdata[0];
                REG_LOWPASS_EN:   lowpass_en_reg   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[4:2]))
            REG_STAGE0_DECAY: prdata = stage0_decay_reg;
            REG_STAGE1_DECAY: prdata = stage1_decay_reg;
            REG_STAGE2_DECAY: prdata = stage2_decay_reg;
            REG_STAGE3_DECAY: prdata = stage3_decay_reg;
            REG_STAGE4_DECAY: prdata = stage4_decay_reg;
            REG_OUTPUT_DECAY: prdata = output_decay_reg;
            REG_FLOOR_EN:     prdata = {31'd0, floor_en_reg};
            REG_LOWPASS_EN:   prdata = {31'd0, lowpass_en_reg};
            default:          prdata = '0;
        endcase
    end

    // ---------------- divisor cells ----------------
    // The divisors circulate: the head cell feeds the stage being worked on,
    // and its updated value enters at the tail. After all stages they are
    // back in place.
    genvar gi;
    generate
        for (gi = 0; gi < STAGE_COUNT; gi++)
        begin : g_cell
            logic [31:0] cell_in;
            if (gi == STAGE_COUNT - 1)
            begin : g_tail
                assign cell_in = upd_nd;
            end
            else
            begin : g_mid
                assign cell_in = cell_out[gi+1];
            end
            aal_cell #(
                .RESET_VALUE (REST_THR[gi])
            ) u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (cell_shift),
                .d_in  (cell_in),
                .d_out (cell_out[gi])
            );
        end
    endgenerate

    assign head_d     = cell_out[0];
    assign cell_shift = (state_reg == ST_U3);
    assign idx_ext    = 3'(idx_reg);
    assign rest_cur   = REST_THR[idx_ext];

    always_comb
    begin
        case (idx_ext)
            3'd0:    dec_cur = stage0_decay_reg;
            3'd1:    dec_cur = stage1_decay_reg;
            3'd2:    dec_cur = stage2_decay_reg;
            3'd3:    dec_cur = stage3_decay_reg;
            default: dec_cur = stage4_decay_reg;
        endcase
    end

    // divisor lowpass with optional floor
    assign upd_sum = acc_reg + mul_reg;
    always_comb
    begin
        upd_nd = upd_sum[63:32];
        if (floor_en_reg && (upd_nd < rest_cur))
        begin
            upd_nd = rest_cur;
        end
    end

    // quotient would exceed 32 bits, or divisor zero
    assign q_sat = (head_d == 32'd0) || ({6'd0, x_reg} >= {head_d, 6'd0});

    // ---------------- shared divider ----------------
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.rem_init = {8'd0, x_reg[31:6]};
        div_req.low      = {x_reg[5:0], 26'd0};
        div_req.den      = {2'b00, head_d};
        if (state_reg == ST_CHK)
        begin
            div_req.start = !q_sat;
        end
        else if (state_reg == ST_SIG)
        begin
            div_req.start    = 1'b1;
            div_req.rem_init = {3'd0, FACTOR_Q26};
            div_req.low      = '0;
            div_req.den      = {1'b0, ONE_Q32} + {1'b0, p_reg};
        end
    end

    aal_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quot  (div_quot)
    );

    // ---------------- shared multiplier ----------------
    assign t_sel = (k_reg == 3'd6) ? {1'b0, t_reg[29:1]} : t_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_AMUL:
            begin
                mul_a = {2'b00, q_reg - ONE_Q26};
                mul_b = {2'b00, EXPFAC_Q32};
            end
            ST_H1:
            begin
                mul_a = {4'd0, a_reg};
                mul_b = {1'b0, p_reg};
            end
            ST_H3:
            begin
                mul_a = {4'd0, t_sel};
                mul_b = {2'b00, (k_reg == 3'd5) ? RECIP5 : RECIP3};
            end
            ST_S1:
            begin
                mul_a = {1'b0, p_reg};
                mul_b = {1'b0, p_reg};
            end
            ST_U1:
            begin
                mul_a = {2'b00, dec_cur};
                mul_b = {2'b00, head_d};
            end
            ST_U2:
            begin
                mul_a = {1'b0, ONE_Q32 - {1'b0, dec_cur}};
                mul_b = {2'b00, q_reg};
            end
            ST_R1:
            begin
                mul_a = {2'b00, x_reg} - {2'b00, REST_THR[LAST]};
                mul_b = {2'b00, DB_SCALE[LAST]};
            end
            ST_L1:
            begin
                mul_a = {2'b00, output_decay_reg};
                mul_b = 34'(ofv_reg);
            end
            ST_L2:
            begin
                mul_a = {1'b0, ONE_Q32 - {1'b0, output_decay_reg}};
                mul_b = 34'(val_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        mul_reg <= 68'(mul_a * mul_b);
    end

    // Horner step quotient by k
    always_comb
    begin
        case (k_reg)
            3'd1:    h_quo = t_reg;
            3'd2:    h_quo = {1'b0, t_reg[29:1]};
            3'd3:    h_quo = mul_reg[62:33];
            3'd4:    h_quo = {2'b00, t_reg[29:2]};
            3'd5:    h_quo = mul_reg[63:34];
            default: h_quo = mul_reg[62:33];
        endcase
    end

    // rescale: round half away from zero at bit 31
    assign prod_abs = mul_reg[67] ? -mul_reg : mul_reg;
    assign prod_rnd = (prod_abs + 68'sd1073741824) >>> 31;
    assign prod_val = mul_reg[67] ? -prod_rnd : prod_rnd;

    // output lowpass: floor division by 2^32
    assign lp_sum = acc_reg + mul_reg;
    assign lp_val = lp_sum >>> 32;

    assign in_x = {2'b00, sample, 6'd0};

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            k_reg         <= '0;
            sq_reg        <= '0;
            ofv_reg       <= '0;
            out_valid_reg <= 1'b0;
            x_reg         <= '0;
            q_reg         <= '0;
            a_reg         <= '0;
            t_reg         <= '0;
            p_reg         <= '0;
            acc_reg       <= '0;
            val_reg       <= '0;
            out_reg       <= '0;
        end
        else
        begin
            // in ST_FIN the hand-off below sets the flag itself
            if (out_valid_reg && out_ready && (state_reg != ST_FIN))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        x_reg     <= (in_x < MIN_IN_Q26) ? MIN_IN_Q26 : in_x;
                        idx_reg   <= '0;
                        state_reg <= ST_CHK;
                    end
                end
                ST_CHK:
                begin
                    if (q_sat)
                    begin
                        q_reg     <= 32'hFFFF_FFFF;
                        state_reg <= ST_QCHK;
                    end
                    else
                    begin
                        state_reg <= ST_DIVW;
                    end
                end
                ST_DIVW:
                begin
                    if (div_done)
                    begin
                        q_reg     <= div_quot;
                        state_reg <= ST_QCHK;
                    end
                end
                ST_QCHK:
                begin
                    state_reg <= (q_reg > ONE_Q26) ? ST_AMUL : ST_U1;
                end
                ST_AMUL: state_reg <= ST_A;
                ST_A:
                begin
                    a_reg     <= mul_reg[61:32];
                    p_reg     <= ONE_Q32;
                    k_reg     <= 3'd6;
                    state_reg <= ST_H1;
                end
                ST_H1: state_reg <= ST_H2;
                ST_H2:
                begin
                    t_reg     <= mul_reg[61:32];
                    state_reg <= ST_H3;
                end
                ST_H3: state_reg <= ST_H4;
                ST_H4:
                begin
                    p_reg <= ONE_Q32 - {3'd0, h_quo};
                    k_reg <= k_reg - 3'd1;
                    if (k_reg == 3'd1)
                    begin
                        sq_reg    <= '0;
                        state_reg <= ST_S1;
                    end
                    else
                    begin
                        state_reg <= ST_H1;
                    end
                end
                ST_S1: state_reg <= ST_S2;
                ST_S2:
                begin
                    // a value of exactly one stays one
                    if (!p_reg[32])
                    begin
                        p_reg <= mul_reg[64:32];
                    end
                    sq_reg <= sq_reg + 3'd1;
                    state_reg <= (sq_reg == 3'd5) ? ST_SIG : ST_S1;
                end
                ST_SIG: state_reg <= ST_SIGW;
                ST_SIGW:
                begin
                    if (div_done)
                    begin
                        q_reg     <= div_quot - OFFSET_Q26;
                        state_reg <= ST_U1;
                    end
                end
                ST_U1: state_reg <= ST_U2;
                ST_U2:
                begin
                    acc_reg   <= mul_reg;
                    state_reg <= ST_U3;
                end
                ST_U3:
                begin
                    x_reg <= q_reg;
                    if (idx_reg == LAST_IDX)
                    begin
                        state_reg <= ST_R1;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_CHK;
                    end
                end
                ST_R1: state_reg <= ST_R2;
                ST_R2:
                begin
                    val_reg   <= sat25(prod_val);
                    state_reg <= lowpass_en_reg ? ST_L1 : ST_FIN;
                end
                ST_L1: state_reg <= ST_L2;
                ST_L2:
                begin
                    acc_reg   <= mul_reg;
                    state_reg <= ST_L3;
                end
                ST_L3:
                begin
                    val_reg   <= sat25(lp_val);
                    ofv_reg   <= sat25(lp_val);
                    state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_reg       <= val_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign model_units = out_reg;
endmodule
